// ===== rtl/core/artt_pkg.sv =====
// shared types and constants of the address range type table
package artt_pkg;

    localparam int ADDR_BITS = 48;
    localparam int TYPE_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    // register index as carried in paddr[2]
    localparam logic REG_DEFAULT_TYPE = 1'b0;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] range_size;
        logic [TYPE_BITS-1:0] new_type;
    } t_in_item;

    typedef struct packed {
        logic [TYPE_BITS-1:0] mem_type;
        logic                 matched;
        logic                 table_full;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] range_start;
        logic [ADDR_BITS:0]   range_end;
        logic [TYPE_BITS-1:0] entry_type;
    } t_entry;

    typedef struct packed {
        logic   wr_en;
        logic   rd_en;
        t_entry wr_data;
    } t_mem_req;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

// ===== rtl/core/artt_mem.sv =====
// range entry memory, one write port and one registered read port
module artt_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic                i_clk,
    input  artt_pkg::t_mem_req  i_req,
    input  logic [IW-1:0]       i_wr_addr,
    input  logic [IW-1:0]       i_rd_addr,
    output artt_pkg::t_entry    o_rd_data
);

    artt_pkg::t_entry r_mem [DEPTH];
    artt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/artt_ctrl.sv =====
// sequencer: appends ranges and walks the stored entries on lookup
module artt_ctrl #(
    parameter int MAX_RANGES = 64,
    parameter int IW         = 6,
    parameter int CW         = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  artt_pkg::t_in_item                  i_item,
    input  logic [artt_pkg::TYPE_BITS-1:0]      i_default_type,
    output artt_pkg::t_mem_req                  o_req,
    output logic [IW-1:0]                       o_wr_addr,
    output logic [IW-1:0]                       o_rd_addr,
    input  artt_pkg::t_entry                    i_rd_data,
    output logic                                o_valid,
    output artt_pkg::t_out_item                 o_result
);

    artt_pkg::t_state                   r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [IW-1:0]                      r_idx, n_idx;
    logic [artt_pkg::ADDR_BITS-1:0]     r_addr, n_addr;
    logic                               r_valid, n_valid;
    artt_pkg::t_out_item                r_out, n_out;

    logic          accept;
    logic          full;
    logic          hit;
    logic          last;
    logic [CW-1:0] idx_next;

    assign accept   = i_start && (r_state == artt_pkg::ST_IDLE);
    assign full     = (r_count == CW'(MAX_RANGES));
    assign idx_next = CW'(r_idx) + CW'(1);
    assign last     = (idx_next == r_count);
    assign hit      = ({1'b0, r_addr} >= {1'b0, i_rd_data.range_start})
                   && ({1'b0, r_addr} < i_rd_data.range_end);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_addr    = r_addr;
        n_valid   = 1'b0;
        n_out     = r_out;
        o_req.wr_en = 1'b0;
        o_req.rd_en = 1'b0;
        o_req.wr_data.range_start = i_item.addr;
        o_req.wr_data.range_end   = {1'b0, i_item.addr} + {1'b0, i_item.range_size};
        o_req.wr_data.entry_type  = i_item.new_type;
        o_wr_addr = r_count[IW-1:0];
        o_rd_addr = '0;
        case (r_state)
            artt_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_item.cmd == artt_pkg::CMD_ADD) begin
                        n_valid = 1'b1;
                        n_out.mem_type   = '0;
                        n_out.matched    = 1'b0;
                        n_out.table_full = full;
                        if (!full) begin
                            o_req.wr_en = 1'b1;
                            n_count     = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_valid = 1'b1;
                        n_out.mem_type   = i_default_type;
                        n_out.matched    = 1'b0;
                        n_out.table_full = 1'b0;
                    end else begin
                        // first entry read now, compared next cycle
                        o_req.rd_en = 1'b1;
                        n_idx   = '0;
                        n_addr  = i_item.addr;
                        n_state = artt_pkg::ST_WALK;
                    end
                end
            end
            artt_pkg::ST_WALK: begin
                if (hit || last) begin
                    n_valid = 1'b1;
                    n_out.mem_type   = hit ? i_rd_data.entry_type : i_default_type;
                    n_out.matched    = hit;
                    n_out.table_full = 1'b0;
                    n_state = artt_pkg::ST_IDLE;
                end else begin
                    // overlap the next read with this compare
                    o_req.rd_en = 1'b1;
                    o_rd_addr   = idx_next[IW-1:0];
                    n_idx       = idx_next[IW-1:0];
                end
            end
            default: begin
                n_state = artt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= artt_pkg::ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != artt_pkg::ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.wr_en |-> (r_state == artt_pkg::ST_IDLE) && !full)
        else $error("entry written outside idle or into a full table");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("entry count beyond table depth");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == artt_pkg::ST_WALK) |-> (CW'(r_idx) < r_count))
        else $error("walk index past filled entries");

    a_short_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_item.cmd == artt_pkg::CMD_ADD) || (r_count == '0))) |=> r_valid)
        else $error("add or empty lookup gave no result next cycle");

    a_full_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.table_full) |-> !r_out.matched && (r_out.mem_type == '0))
        else $error("refused add carries lookup fields");

endmodule

// ===== rtl/core/address_range_type_table.sv =====
// top level of the address range type table: config port, sequencer and entry memory
//
// Usage: raise start with an item on i_item while busy is low; the item is
// taken at that clock edge. cmd selects a lookup or the append of a range
// [addr, addr + range_size) with type new_type. Every item yields exactly one
// result on o_result, marked by o_result_valid for a single cycle; the
// receiver cannot hold it off.
// Flow: an add, or a lookup on an empty table, answers in the cycle after it
// is taken and busy never rises. A lookup over n stored ranges reads one entry
// per cycle through the entry memory's single read port, stopping at the first
// hit; the next item may be taken in the cycle the result is shown.
// Configuration: default_type sits at APB byte address 0, written in the access
// phase; pready is always high. Write it only while the block is idle.
// Reset: synchronous, active low; clears the range count, the sequencer and
// default_type. The entry memory is not cleared: entries are only read once
// written.
module address_range_type_table #(
    parameter int MAX_RANGES = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  artt_pkg::t_in_item                    i_item,
    output logic                                  o_result_valid,
    output artt_pkg::t_out_item                   o_result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [artt_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [artt_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [artt_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    logic [artt_pkg::TYPE_BITS-1:0] r_default_type, n_default_type;
    artt_pkg::t_mem_req             mem_req;
    logic [IW-1:0]                  wr_addr;
    logic [IW-1:0]                  rd_addr;
    artt_pkg::t_entry               rd_data;
    logic                           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == artt_pkg::REG_DEFAULT_TYPE);

    always_comb begin
        n_default_type = r_default_type;
        if (cfg_wr) begin
            n_default_type = pwdata[artt_pkg::TYPE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_type <= '0;
        end else begin
            r_default_type <= n_default_type;
        end
    end

    assign prdata = (paddr[2] == artt_pkg::REG_DEFAULT_TYPE)
                  ? {{(artt_pkg::APB_DATA_BITS - artt_pkg::TYPE_BITS){1'b0}}, r_default_type}
                  : '0;

    artt_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_item         (i_item),
        .i_default_type (r_default_type),
        .o_req          (mem_req),
        .o_wr_addr      (wr_addr),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_valid        (o_result_valid),
        .o_result       (o_result)
    );

    artt_mem #(
        .DEPTH (MAX_RANGES),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== bench/address_range_type_table_checker.sv =====
// checker for the address range type table: predicts each result and compares it
module address_range_type_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  artt_pkg::t_in_item                   i_item,
    input  logic                                 i_result_valid,
    input  artt_pkg::t_out_item                  i_result,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [artt_pkg::APB_ADDR_BITS-1:0]   i_paddr,
    input  logic [artt_pkg::APB_DATA_BITS-1:0]   i_pwdata,
    input  logic [artt_pkg::APB_DATA_BITS-1:0]   i_prdata,
    input  logic                                 i_pready,
    output int                                   o_mismatch_count,
    output int                                   o_results_outstanding
);

    logic [artt_pkg::ADDR_BITS-1:0] shadow_start [TABLE_DEPTH];
    logic [artt_pkg::ADDR_BITS:0]   shadow_end   [TABLE_DEPTH];
    logic [artt_pkg::TYPE_BITS-1:0] shadow_type  [TABLE_DEPTH];
    int                             shadow_count;
    logic [artt_pkg::TYPE_BITS-1:0] shadow_default;

    artt_pkg::t_out_item            awaited_results [$];
    int                             mismatches;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // applies one item to the shadow table and returns the answer it must give
    function automatic artt_pkg::t_out_item table_response(input artt_pkg::t_in_item it);
        artt_pkg::t_out_item r;
        logic                found;
        r = '0;
        found = 1'b0;
        if (it.cmd == artt_pkg::CMD_ADD) begin
            if (shadow_count >= TABLE_DEPTH) begin
                r.table_full = 1'b1;
            end else begin
                shadow_start[shadow_count] = it.addr;
                shadow_end[shadow_count] = {1'b0, it.addr} + {1'b0, it.range_size};
                shadow_type[shadow_count] = it.new_type;
                shadow_count++;
            end
        end else begin
            r.mem_type = shadow_default;
            // first range in insertion order wins
            for (int k = 0; k < shadow_count; k++) begin
                if (!found && it.addr >= shadow_start[k]
                        && {1'b0, it.addr} < shadow_end[k]) begin
                    r.mem_type = shadow_type[k];
                    r.matched = 1'b1;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        artt_pkg::t_out_item want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_default = '0;
            awaited_results.delete();
        end else begin
            if (i_result_valid) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %p with no item outstanding", i_result));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.mem_type !== want.mem_type)
                        report_mismatch($sformatf("mem_type got %0d expected %0d",
                                                  i_result.mem_type, want.mem_type));
                    if (i_result.matched !== want.matched)
                        report_mismatch($sformatf("matched got %0b expected %0b",
                                                  i_result.matched, want.matched));
                    if (i_result.table_full !== want.table_full)
                        report_mismatch($sformatf("table_full got %0b expected %0b",
                                                  i_result.table_full, want.table_full));
                end
            end
            if (i_start && !i_busy)
                awaited_results.push_back(table_response(i_item));
            // only register index 0 exists, any other index is ignored
            if (i_psel && i_penable && i_pready
                    && i_paddr[2] == artt_pkg::REG_DEFAULT_TYPE) begin
                if (i_pwrite) begin
                    shadow_default = i_pwdata[artt_pkg::TYPE_BITS-1:0];
                end else if (i_prdata[artt_pkg::TYPE_BITS-1:0] !== shadow_default) begin
                    report_mismatch($sformatf("default_type read %0d expected %0d",
                                              i_prdata[artt_pkg::TYPE_BITS-1:0],
                                              shadow_default));
                end
            end
        end
        o_results_outstanding <= awaited_results.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// ===== bench/address_range_type_table_tb.sv =====
// stimulus and verdict for the address range type table, with the checker beside the block
module address_range_type_table_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 322;
    localparam logic [artt_pkg::APB_ADDR_BITS-1:0] DEFAULT_TYPE_ADDR =
        {artt_pkg::REG_DEFAULT_TYPE, 2'b00};
    localparam logic [artt_pkg::APB_ADDR_BITS-1:0] UNMAPPED_ADDR =
        {~artt_pkg::REG_DEFAULT_TYPE, 2'b00};

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    artt_pkg::t_in_item                 i_item;
    logic                               o_result_valid;
    artt_pkg::t_out_item                o_result;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [artt_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [artt_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [artt_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    int                                 mismatch_count;
    int                                 results_outstanding;

    // ranges sent so far, used only to aim lookups at interesting addresses
    logic [artt_pkg::ADDR_BITS-1:0]     sent_start [TABLE_DEPTH];
    logic [artt_pkg::ADDR_BITS:0]       sent_end   [TABLE_DEPTH];
    int                                 sent_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    address_range_type_table #(
        .MAX_RANGES(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    address_range_type_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_inst (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (start),
        .i_busy                (busy),
        .i_item                (i_item),
        .i_result_valid        (o_result_valid),
        .i_result              (o_result),
        .i_psel                (psel),
        .i_penable             (penable),
        .i_pwrite              (pwrite),
        .i_paddr               (paddr),
        .i_pwdata              (pwdata),
        .i_prdata              (prdata),
        .i_pready              (pready),
        .o_mismatch_count      (mismatch_count),
        .o_results_outstanding (results_outstanding)
    );

    function automatic logic [artt_pkg::ADDR_BITS-1:0] rand_addr48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // addresses packed into four 64 KiB windows so that ranges overlap often
    function automatic logic [artt_pkg::ADDR_BITS-1:0] clustered_addr();
        return (48'($urandom_range(0, 3)) << 40) | 48'($urandom_range(0, 65535));
    endfunction

    function automatic logic [artt_pkg::ADDR_BITS-1:0] lookup_addr();
        int                             idx;
        logic [artt_pkg::ADDR_BITS:0]   span;
        logic [63:0]                    offset;
        if (sent_count == 0 || $urandom_range(0, 9) < 3)
            return ($urandom_range(0, 1) == 0) ? clustered_addr() : rand_addr48();
        idx = $urandom_range(0, sent_count - 1);
        span = sent_end[idx] - {1'b0, sent_start[idx]};
        case ($urandom_range(0, 4))
            0: return sent_start[idx];
            1: return artt_pkg::ADDR_BITS'(sent_end[idx] - 1'b1);
            2: return artt_pkg::ADDR_BITS'(sent_end[idx]);
            3: return sent_start[idx] - 1'b1;
            default: begin
                if (span == '0)
                    return sent_start[idx];
                offset = {$urandom, $urandom} % 64'(span);
                return artt_pkg::ADDR_BITS'({1'b0, sent_start[idx]} + 49'(offset));
            end
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [artt_pkg::ADDR_BITS-1:0] a,
                             input logic [artt_pkg::ADDR_BITS-1:0] sz,
                             input logic [artt_pkg::TYPE_BITS-1:0] ty);
        artt_pkg::t_in_item it;
        it.cmd = cmd;
        it.addr = a;
        it.range_size = sz;
        it.new_type = ty;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (cmd == artt_pkg::CMD_ADD && sent_count < TABLE_DEPTH) begin
            sent_start[sent_count] = a;
            sent_end[sent_count] = {1'b0, a} + {1'b0, sz};
            sent_count++;
        end
    endtask

    task automatic send_random_add();
        logic [artt_pkg::ADDR_BITS-1:0] a;
        logic [artt_pkg::ADDR_BITS-1:0] sz;
        int                             pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            a = clustered_addr();
            sz = 48'($urandom_range(0, 4096));
        end else if (pick < 13) begin
            a = clustered_addr();
            sz = '0;
        end else if (pick < 16) begin
            a = rand_addr48();
            sz = rand_addr48();
        end else if (pick < 18) begin
            a = '1 - 48'($urandom_range(0, 255));
            sz = rand_addr48();
        end else begin
            a = rand_addr48();
            sz = rand_addr48() >> $urandom_range(0, 40);
        end
        send_item(artt_pkg::CMD_ADD, a, sz, artt_pkg::TYPE_BITS'($urandom));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (results_outstanding != 0);
    endtask

    // one transfer, after which the bus returns to idle
    task automatic apb_access(input logic wr, input logic [artt_pkg::APB_ADDR_BITS-1:0] a,
                              input logic [artt_pkg::APB_DATA_BITS-1:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // write with junk in the upper bits, then read it back
    task automatic set_default_type(input logic [artt_pkg::TYPE_BITS-1:0] ty);
        apb_access(1'b1, DEFAULT_TYPE_ADDR, {28'($urandom_range(0, 32'h0FFF_FFFF)), ty});
        apb_access(1'b0, DEFAULT_TYPE_ADDR, '0);
    endtask

    initial begin
        int                             idle_odds;
        logic [artt_pkg::TYPE_BITS-1:0] phase_default;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sent_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_default_type(4'h9);

        // empty table, then empty range, boundaries, overlap and top of address space
        send_item(artt_pkg::CMD_LOOKUP, '0, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, '1, '1, '1);
        send_item(artt_pkg::CMD_ADD, '0, '0, 4'hF);
        send_item(artt_pkg::CMD_LOOKUP, '0, '0, '0);
        send_item(artt_pkg::CMD_ADD, 48'h1000, 48'h100, 4'h3);
        send_item(artt_pkg::CMD_LOOKUP, 48'h1000, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'h10FF, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'h1100, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'h0FFF, '0, '0);
        send_item(artt_pkg::CMD_ADD, 48'h1080, 48'h1000, 4'hA);
        send_item(artt_pkg::CMD_LOOKUP, 48'h1090, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'h1100, '1, 4'h7);
        send_item(artt_pkg::CMD_ADD, '1, '1, 4'h5);
        send_item(artt_pkg::CMD_LOOKUP, '1, '0, '0);
        send_item(artt_pkg::CMD_ADD, 48'h8000_0000_0000, 48'h4000_0000_0000, 4'h0);
        send_item(artt_pkg::CMD_LOOKUP, 48'h8000_0000_0000, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'hBFFF_FFFF_FFFF, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'hC000_0000_0000, '0, '0);
        send_item(artt_pkg::CMD_ADD, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 4'hC);
        send_item(artt_pkg::CMD_LOOKUP, 48'hFFFF_FFFF_FFFE, '0, '0);
        send_item(artt_pkg::CMD_LOOKUP, 48'h5555_5555_5554, '0, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            idle_cycles(1);
            wait_drained();
            case (phase)
                0: phase_default = 4'h0;
                1, 5: phase_default = 4'hF;
                default: phase_default = artt_pkg::TYPE_BITS'($urandom);
            endcase
            set_default_type(phase_default);
            // a write to an unmapped index must leave default_type alone
            if (phase == 3) begin
                apb_access(1'b1, UNMAPPED_ADDR, {28'h0, ~phase_default});
                apb_access(1'b0, DEFAULT_TYPE_ADDR, '0);
            end
            idle_odds = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0)
                    idle_odds = $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0)
                    send_random_add();
                else
                    send_item(artt_pkg::CMD_LOOKUP, lookup_addr(), rand_addr48(),
                              artt_pkg::TYPE_BITS'($urandom));
                if (phase < PHASES - 1 && idle_odds != 0 && $urandom_range(0, 3) < idle_odds)
                    idle_cycles($urandom_range(1, 7));
            end
        end

        idle_cycles(1);
        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("address_range_type_table test passed");
        else
            $display("address_range_type_table test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("address_range_type_table test failed");
        $finish;
    end

endmodule
